/* sv/enc8b10b_pkg.sv */
// Shared types, code tables and constants for the 8b/10b encoder.
package enc8b10b_pkg;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 10;
    localparam int SIX_W  = 6;
    localparam int FOUR_W = 4;
    localparam int X_W    = 5;
    localparam int Y_W    = 3;

    // Sub-block values with special handling
    localparam logic [X_W-1:0] X_D07 = 5'd7;
    localparam logic [X_W-1:0] X_D11 = 5'd11;
    localparam logic [X_W-1:0] X_D13 = 5'd13;
    localparam logic [X_W-1:0] X_D14 = 5'd14;
    localparam logic [X_W-1:0] X_D17 = 5'd17;
    localparam logic [X_W-1:0] X_D18 = 5'd18;
    localparam logic [X_W-1:0] X_D20 = 5'd20;
    localparam logic [X_W-1:0] X_K23 = 5'd23;
    localparam logic [X_W-1:0] X_K27 = 5'd27;
    localparam logic [X_W-1:0] X_K28 = 5'd28;
    localparam logic [X_W-1:0] X_K29 = 5'd29;
    localparam logic [X_W-1:0] X_K30 = 5'd30;
    localparam logic [Y_W-1:0] Y_3   = 3'd3;
    localparam logic [Y_W-1:0] Y_7   = 3'd7;

    // 6-bit part of K.28 at negative disparity
    localparam logic [SIX_W-1:0]  SIX_K28_NEG = 6'h0F;
    // A7 alternate 4-bit part at negative disparity
    localparam logic [FOUR_W-1:0] FOUR_A7_NEG = 4'h7;

    // 5b/6b codes at negative disparity, abcdei with a at bit 5
    localparam logic [SIX_W-1:0] SIX_NEG [32] = '{
        6'h27, 6'h1D, 6'h2D, 6'h31, 6'h35, 6'h29, 6'h19, 6'h38,
        6'h39, 6'h25, 6'h15, 6'h34, 6'h0D, 6'h2C, 6'h1C, 6'h17,
        6'h1B, 6'h23, 6'h13, 6'h32, 6'h0B, 6'h2A, 6'h1A, 6'h3A,
        6'h33, 6'h26, 6'h16, 6'h36, 6'h0E, 6'h2E, 6'h1E, 6'h2B
    };

    // 3b/4b data codes at negative disparity, fghj with f at bit 3 (P7 form)
    localparam logic [FOUR_W-1:0] FOUR_DATA_NEG [8] = '{
        4'hB, 4'h9, 4'h5, 4'hC, 4'hD, 4'hA, 4'h6, 4'hE
    };

    // 3b/4b control codes at negative disparity
    localparam logic [FOUR_W-1:0] FOUR_CTRL_NEG [8] = '{
        4'hB, 4'h6, 4'hA, 4'hC, 4'hD, 4'h5, 4'h9, 4'h7
    };

    // Result of encoding one item
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              ok;
        logic              rd;
    } t_enc_res;

endpackage

/* sv/encoder_8b10b_core.sv */
// 8b/10b line encoder top level: input register, encode logic, result register.
// 8b/10b encoder. Each accepted item (a byte HGF EDCBA plus a control flag)
// yields one result: the ten-bit code group abcdeifghj with a at bit 9, a
// valid flag, and the running disparity after the symbol. Running disparity
// resets to negative. Data bytes use the standard 5b/6b and 3b/4b tables with
// the A7 alternate for D.17/18/20.7 at negative and D.11/13/14.7 at positive
// disparity; control requests produce K.28.0-7 and K.23/27/29/30.7, and any
// other control value returns code 0, valid 0, disparity unchanged.
// Throughput is one item per clock while the output is not stalled: the input
// register takes the item at the accepting edge, and the result register loads
// it from the encode stage once the result register is empty or being taken.
// The one-bit disparity loop closes within the single encode stage, so
// back-to-back items need no bubbles. Output stall propagates to o_in_stall
// combinationally only while the input register holds an item.
module encoder_8b10b_core
    import enc8b10b_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_is_control,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CODE_W-1:0] o_code_group,
    output logic              o_valid_res,
    output logic              o_disparity_positive
);

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_ctrl;
    // result register
    logic              r_out_valid;
    logic [CODE_W-1:0] r_code;
    logic              r_ok;
    logic              r_out_rd;
    // running disparity (1 = positive)
    logic              r_rd;
    logic              n_rd;

    logic              adv;      // encode stage moves into result register
    t_enc_res          enc_res;

    // result register frees up when empty or being taken
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !adv;

    enc8b10b_enc u_enc (
        .i_byte (r_byte),
        .i_ctrl (r_ctrl),
        .i_rd   (r_rd),
        .o_res  (enc_res)
    );

    // disparity commits only when an item leaves the encode stage
    assign n_rd = (adv && r_in_valid) ? enc_res.rd : r_rd;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd        <= 1'b0;
        end else begin
            r_rd <= n_rd;
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_byte <= i_data_byte;
            r_ctrl <= i_is_control;
        end
        if (adv && r_in_valid) begin
            r_code   <= enc_res.code;
            r_ok     <= enc_res.ok;
            r_out_rd <= enc_res.rd;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_code_group         = r_code;
    assign o_valid_res          = r_ok;
    assign o_disparity_positive = r_out_rd;

endmodule

/* sv/enc8b10b_enc.sv */
// Combinational 5b/6b and 3b/4b encode of one byte at a given running disparity.
module enc8b10b_enc
    import enc8b10b_pkg::*;
(
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_ctrl,
    input  logic              i_rd,
    output t_enc_res          o_res
);

    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic              k28;
    logic              ok;
    logic [SIX_W-1:0]  six_base;
    logic [SIX_W-1:0]  six;
    logic              six_unbal;
    logic              six_alt;
    logic              rd_mid;
    logic              use_a7;
    logic [FOUR_W-1:0] four_base;
    logic [FOUR_W-1:0] four;
    logic              four_unbal;
    logic              four_alt;

    assign x   = i_byte[X_W-1:0];
    assign y   = i_byte[BYTE_W-1:X_W];
    assign k28 = i_ctrl && (x == X_K28);

    assign ok = !i_ctrl || (x == X_K28) ||
                ((y == Y_7) && ((x == X_K23) || (x == X_K27) ||
                                (x == X_K29) || (x == X_K30)));

    // 5b/6b
    always_comb begin
        six_base  = k28 ? SIX_K28_NEG : SIX_NEG[x];
        six_unbal = ($countones(six_base) != 3);
        six_alt   = six_unbal || (!i_ctrl && (x == X_D07)) || k28;
        six       = (i_rd && six_alt) ? ~six_base : six_base;
        // complement keeps the imbalance, so the flip follows the base code
        rd_mid    = i_rd ^ six_unbal;
    end

    // 3b/4b, chosen by the disparity left by the 6-bit part
    always_comb begin
        use_a7 = (y == Y_7) &&
                 ((!rd_mid && ((x == X_D17) || (x == X_D18) || (x == X_D20))) ||
                  ( rd_mid && ((x == X_D11) || (x == X_D13) || (x == X_D14))));
        if (i_ctrl) begin
            four_base = FOUR_CTRL_NEG[y];
            four_alt  = 1'b1;
        end else begin
            four_base = use_a7 ? FOUR_A7_NEG : FOUR_DATA_NEG[y];
            four_alt  = ($countones(four_base) != 2) || (y == Y_3);
        end
        four_unbal = ($countones(four_base) != 2);
        four       = (rd_mid && four_alt) ? ~four_base : four_base;
    end

    always_comb begin
        if (ok) begin
            o_res.code = {six, four};
            o_res.ok   = 1'b1;
            o_res.rd   = rd_mid ^ four_unbal;
        end else begin
            o_res.code = '0;
            o_res.ok   = 1'b0;
            o_res.rd   = i_rd;
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the 8b/10b encoder core.
module tb_top;
    import enc8b10b_pkg::*;

    // Clock and reset
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 12;
    // Long receiver hold-off used to back the encoder up into its input
    localparam int HOLD_CYCLES  = 150;
    // Idle cycles after the last result
    localparam int DRAIN_CYCLES = 10;

    // D.0.1: unbalanced 6-bit part, balanced 4-bit part, so it flips disparity
    localparam logic [BYTE_W-1:0] FLIP_BYTE = {3'd1, 5'd0};

    // 5b/6b codes at negative disparity, abcdei, indexed by EDCBA
    localparam logic [SIX_W-1:0] ABCDEI_RDM [32] = '{
        6'b100111, 6'b011101, 6'b101101, 6'b110001,
        6'b110101, 6'b101001, 6'b011001, 6'b111000,
        6'b111001, 6'b100101, 6'b010101, 6'b110100,
        6'b001101, 6'b101100, 6'b011100, 6'b010111,
        6'b011011, 6'b100011, 6'b010011, 6'b110010,
        6'b001011, 6'b101010, 6'b011010, 6'b111010,
        6'b110011, 6'b100110, 6'b010110, 6'b110110,
        6'b001110, 6'b101110, 6'b011110, 6'b101011
    };
    // K.28 6-bit part at negative disparity
    localparam logic [SIX_W-1:0] K28_ABCDEI = 6'b001111;

    // 3b/4b data codes at negative disparity, fghj, indexed by HGF (P7 form)
    localparam logic [FOUR_W-1:0] FGHJ_D_RDM [8] = '{
        4'b1011, 4'b1001, 4'b0101, 4'b1100,
        4'b1101, 4'b1010, 4'b0110, 4'b1110
    };
    // A7 alternate at negative disparity
    localparam logic [FOUR_W-1:0] FGHJ_A7_RDM = 4'b0111;
    // 3b/4b control codes at negative disparity
    localparam logic [FOUR_W-1:0] FGHJ_K_RDM [8] = '{
        4'b1011, 4'b0110, 4'b1010, 4'b1100,
        4'b1101, 4'b0101, 4'b1001, 4'b0111
    };

    // One predicted result item
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              ok;
        logic              rd_pos;
    } t_symbol;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic [BYTE_W-1:0] in_byte   = '0;
    logic              in_ctrl   = 1'b0;
    logic              out_stall = 1'b0;
    wire               in_stall;
    wire               out_valid;
    wire  [CODE_W-1:0] code_group;
    wire               valid_res;
    wire               disparity_pos;

    // Predicted running disparity, updated at every accepted input item
    logic    model_rd_pos = 1'b0;
    // Code groups still owed by the encoder, oldest first
    t_symbol pending_symbols [$];

    int fail_count      = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int ctrl_sent       = 0;
    int bad_ctrl_sent   = 0;
    int in_stall_cycles = 0;

    // Pacing knobs, changed per test
    int   tx_max_gap  = 10;
    int   rx_max_wait = 10;
    int   rx_left     = 0;
    logic hold_req    = 1'b0;
    logic hold_active = 1'b0;

    encoder_8b10b_core i_dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_stall           (in_stall),
        .i_data_byte          (in_byte),
        .i_is_control         (in_ctrl),
        .o_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .o_code_group         (code_group),
        .o_valid_res          (valid_res),
        .o_disparity_positive (disparity_pos)
    );

    always #HALF_PERIOD clk = ~clk;

    // Encode one symbol from the running disparity rd; the returned rd_pos is
    // the disparity after it (unchanged for an illegal K request).
    function automatic t_symbol encode_symbol(input logic [BYTE_W-1:0] b,
                                              input logic k, input logic rd);
        t_symbol           r;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [SIX_W-1:0]  six;
        logic [FOUR_W-1:0] four;
        logic              legal;
        x = b[X_W-1:0];
        y = b[BYTE_W-1:X_W];
        legal = !k || x == X_K28 ||
                (y == Y_7 && (x == X_K23 || x == X_K27 || x == X_K29 || x == X_K30));
        if (!legal) begin
            r.code   = '0;
            r.ok     = 1'b0;
            r.rd_pos = rd;
            return r;
        end
        // 5b/6b: unbalanced codes, D.7 and K.28 have a complemented form
        six = (k && x == X_K28) ? K28_ABCDEI : ABCDEI_RDM[x];
        if (rd && ($countones(six) != 3 || (!k && x == X_D07) || (k && x == X_K28)))
            six = ~six;
        if ($countones(six) != 3)
            rd = ~rd;
        // 3b/4b, chosen by the disparity left by the 6-bit part
        if (k) begin
            four = FGHJ_K_RDM[y];
            if (rd)
                four = ~four;
        end else begin
            if (y == Y_7 && ((!rd && (x == X_D17 || x == X_D18 || x == X_D20)) ||
                             (rd && (x == X_D11 || x == X_D13 || x == X_D14))))
                four = FGHJ_A7_RDM;
            else
                four = FGHJ_D_RDM[y];
            if (rd && ($countones(four) != 2 || y == Y_3))
                four = ~four;
        end
        if ($countones(four) != 2)
            rd = ~rd;
        r.code   = {six, four};
        r.ok     = 1'b1;
        r.rd_pos = rd;
        return r;
    endfunction

    // Byte for the n-th legal K symbol: K.28.0-7, then K.23/27/29/30.7
    function automatic logic [BYTE_W-1:0] k_symbol(input int n);
        case (n)
            8:       return {Y_7, X_K23};
            9:       return {Y_7, X_K27};
            10:      return {Y_7, X_K29};
            11:      return {Y_7, X_K30};
            default: return {n[Y_W-1:0], X_K28};
        endcase
    endfunction

    // Offer one item after a random gap; returns once the encoder takes it.
    // Valid stays high on return so back-to-back items need no bubble.
    task automatic send_symbol(input logic [BYTE_W-1:0] b, input logic k);
        int      gap;
        t_symbol want;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_ctrl  <= k;
        do
            @(posedge clk);
        while (in_stall);
        want = encode_symbol(b, k, model_rd_pos);
        model_rd_pos = want.rd_pos;
        pending_symbols.push_back(want);
        items_sent++;
        if (k)
            ctrl_sent++;
        if (k && !want.ok)
            bad_ctrl_sent++;
    endtask

    // Bring the running disparity to the wanted sign with one flipping item
    task automatic steer_disparity(input logic want_pos);
        if (model_rd_pos != want_pos)
            send_symbol(FLIP_BYTE, 1'b0);
    endtask

    task automatic test_data_corners();
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        // D.7.y has a complemented form although it is balanced
        steer_disparity(1'b0);
        send_symbol({3'd1, X_D07}, 1'b0);
        steer_disparity(1'b1);
        send_symbol({3'd1, X_D07}, 1'b0);
        // D.x.3 likewise for the 4-bit part
        send_symbol({Y_3, 5'd5}, 1'b0);
    endtask

    task automatic test_alternate_forms();
        logic [X_W-1:0] neg_xs [3];
        logic [X_W-1:0] pos_xs [3];
        neg_xs = '{X_D17, X_D18, X_D20};
        pos_xs = '{X_D11, X_D13, X_D14};
        // A7 at negative disparity for D.17/18/20.7
        foreach (neg_xs[n]) begin
            steer_disparity(1'b0);
            send_symbol({Y_7, neg_xs[n]}, 1'b0);
        end
        // and at positive disparity for D.11/13/14.7
        foreach (pos_xs[n]) begin
            steer_disparity(1'b1);
            send_symbol({Y_7, pos_xs[n]}, 1'b0);
        end
    endtask

    task automatic test_control_symbols();
        for (int n = 0; n < 12; n++)
            send_symbol(k_symbol(n), 1'b1);
    endtask

    task automatic test_invalid_control();
        // illegal K requests: no code, disparity held
        send_symbol(8'h00, 1'b1);
        send_symbol({3'd0, X_K23}, 1'b1);
        send_symbol(8'hFF, 1'b1);
    endtask

    // Receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure();
        tx_max_gap = 0;
        hold_req   = 1'b1;
        for (int n = 0; n < 48; n++)
            send_symbol(BYTE_W'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_random_traffic(input int count, input int tx_gap,
                                       input int rx_wait);
        int pick;
        tx_max_gap  = tx_gap;
        rx_max_wait = rx_wait;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                send_symbol(BYTE_W'($urandom_range(0, 255)), 1'b0);
            else if (pick < 9)
                send_symbol(k_symbol($urandom_range(0, 11)), 1'b1);
            else
                send_symbol(BYTE_W'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // Receiver pacing: after each result, stall for a random number of cycles.
    // During the hold-off window it stalls regardless.
    always @(posedge clk) begin : rx_pacing
        int draw;
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_left   <= 0;
        end else if (hold_active) begin
            out_stall <= 1'b1;
            rx_left   <= 0;
        end else if (out_valid && !out_stall) begin
            draw = $urandom_range(0, rx_max_wait);
            out_stall <= (draw != 0);
            rx_left   <= draw;
        end else if (rx_left > 1) begin
            rx_left <= rx_left - 1;
        end else begin
            rx_left   <= 0;
            out_stall <= 1'b0;
        end
    end

    // Hold-off window, counted here once the backpressure test asks for it
    initial begin : rx_hold_off
        wait (hold_req);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Compare every accepted result with the oldest predicted code group
    always @(posedge clk) begin : result_check
        t_symbol want;
        if (rst_n && in_valid && in_stall)
            in_stall_cycles++;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_symbols.size() == 0) begin
                $error("result with nothing pending: code_group=%h valid_res=%b",
                       code_group, valid_res);
                fail_count++;
            end else begin
                want = pending_symbols.pop_front();
                results_checked++;
                if (code_group !== want.code) begin
                    $error("code_group: expected %h, got %h", want.code, code_group);
                    fail_count++;
                end
                if (valid_res !== want.ok) begin
                    $error("valid_res: expected %b, got %b", want.ok, valid_res);
                    fail_count++;
                end
                if (disparity_pos !== want.rd_pos) begin
                    $error("disparity_positive: expected %b, got %b",
                           want.rd_pos, disparity_pos);
                    fail_count++;
                end
            end
        end
    end

    initial begin : run_tests
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_data_corners();
        test_alternate_forms();
        test_control_symbols();
        test_invalid_control();
        test_backpressure();
        // random traffic with both sides idling, neither, and each alone
        test_random_traffic(450, 10, 10);
        test_random_traffic(450, 0, 0);
        test_random_traffic(450, 0, 10);
        test_random_traffic(450, 10, 0);

        in_valid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d items (%0d K requests, %0d of them illegal), %0d results",
                 items_sent, ctrl_sent, bad_ctrl_sent, results_checked);
        $display("Encoder held its input back for %0d cycles; %0d mismatches",
                 in_stall_cycles, fail_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
